@@ design/cbfp_pkg.sv @@
// shared types and constants for the camera block frame parser
package cbfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int COUNT_W = 6;
    localparam int KIND_W  = 2;
    localparam int NUM_HELD = 5;

    localparam logic [WORD_W-1:0]  START_NORMAL     = 16'haa55;
    localparam logic [WORD_W-1:0]  START_CC         = 16'haa56;
    localparam logic [WORD_W-1:0]  START_REVERSED   = 16'h55aa;
    localparam logic [WORD_W-1:0]  SEEK_IDLE_WORD   = 16'hffff;
    localparam logic [COUNT_W-1:0] MAX_BLOCKS_RESET = 6'd30;

    // index of the last data word in normal and color-code blocks
    localparam logic [2:0] LAST_NORMAL = 3'd4;
    localparam logic [2:0] LAST_CC     = 3'd5;

    typedef enum logic [KIND_W-1:0] {
        KIND_BLOCK     = 2'd0,
        KIND_FRAME_END = 2'd1,
        KIND_CSUM_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SEEK   = 2'd0,
        PH_CHECK  = 2'd1,
        PH_FIELDS = 2'd2,
        PH_TRAIL  = 2'd3
    } phase_t;

    typedef struct packed {
        kind_t               kind;
        logic [WORD_W-1:0]   signature;
        logic [WORD_W-1:0]   pos_x;
        logic [WORD_W-1:0]   pos_y;
        logic [WORD_W-1:0]   box_width;
        logic [WORD_W-1:0]   box_height;
        logic [WORD_W-1:0]   angle;
        logic                is_color_code;
        logic [COUNT_W-1:0]  frame_count;
    } result_t;

endpackage

@@ design/cbfp_input_skid.sv @@
// input byte register with a skid slot so that the stall is registered
module cbfp_input_skid (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [cbfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       advance,
    output logic                       stage_valid,
    output logic [cbfp_pkg::BYTE_W-1:0] stage_byte
);
    import cbfp_pkg::*;

    logic              stage_valid_reg, stage_valid_next;
    logic [BYTE_W-1:0] stage_byte_reg, stage_byte_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [BYTE_W-1:0] skid_byte_reg, skid_byte_next;
    logic              accepted;

    assign in_stall    = skid_valid_reg;
    assign accepted    = in_valid && !skid_valid_reg;
    assign stage_valid = stage_valid_reg;
    assign stage_byte  = stage_byte_reg;

    // stage and skid next values
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_byte_next  = stage_byte_reg;
        skid_valid_next  = skid_valid_reg;
        skid_byte_next   = skid_byte_reg;
        if (stage_valid_reg && !advance)
        begin
            if (accepted)
            begin
                skid_valid_next = 1'b1;
                skid_byte_next  = rx_byte;
            end
        end
        else if (skid_valid_reg)
        begin
            stage_valid_next = 1'b1;
            stage_byte_next  = skid_byte_reg;
            skid_valid_next  = 1'b0;
        end
        else if (accepted)
        begin
            stage_valid_next = 1'b1;
            stage_byte_next  = rx_byte;
        end
        else
        begin
            stage_valid_next = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // payload bytes
    always_ff @(posedge clk)
    begin
        stage_byte_reg <= stage_byte_next;
        skid_byte_reg  <= skid_byte_next;
    end

endmodule

@@ design/cbfp_parser.sv @@
// byte pairing, frame state machine and checksum, one byte per step
module cbfp_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [cbfp_pkg::BYTE_W-1:0]   byte_in,
    input  logic [cbfp_pkg::COUNT_W-1:0]  max_blocks,
    output logic                          res_valid,
    output cbfp_pkg::result_t             res
);
    import cbfp_pkg::*;

    phase_t             phase_reg, phase_next;
    logic               byte_phase_reg, byte_phase_next;
    logic [BYTE_W-1:0]  low_half_reg, low_half_next;
    logic               drop_reg, drop_next;
    logic [WORD_W-1:0]  prev_word_reg, prev_word_next;
    logic [WORD_W-1:0]  exp_sum_reg, exp_sum_next;
    logic [WORD_W-1:0]  run_sum_reg, run_sum_next;
    logic [2:0]         field_idx_reg, field_idx_next;
    logic               cc_mode_reg, cc_mode_next;
    logic [COUNT_W-1:0] good_reg, good_next;
    logic [WORD_W-1:0]  held_reg [NUM_HELD];
    logic [WORD_W-1:0]  held_next [NUM_HELD];

    logic [WORD_W-1:0]  word;
    logic               is_start;
    logic [WORD_W-1:0]  sum_now;
    logic [2:0]         last_idx;

    assign word     = {byte_in, low_half_reg};
    assign is_start = (word == START_NORMAL) || (word == START_CC);
    assign sum_now  = run_sum_reg + word;
    assign last_idx = cc_mode_reg ? LAST_CC : LAST_NORMAL;

    // next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        byte_phase_next = byte_phase_reg;
        low_half_next   = low_half_reg;
        drop_next       = drop_reg;
        prev_word_next  = prev_word_reg;
        exp_sum_next    = exp_sum_reg;
        run_sum_next    = run_sum_reg;
        field_idx_next  = field_idx_reg;
        cc_mode_next    = cc_mode_reg;
        good_next       = good_reg;
        for (int i = 0; i < NUM_HELD; i++)
        begin
            held_next[i] = held_reg[i];
        end
        res_valid = 1'b0;
        res       = '0;

        if (step)
        begin
            if (drop_reg)
            begin
                drop_next = 1'b0;
            end
            else if (!byte_phase_reg)
            begin
                low_half_next   = byte_in;
                byte_phase_next = 1'b1;
            end
            else
            begin
                byte_phase_next = 1'b0;
                case (phase_reg)
                    PH_SEEK:
                    begin
                        if (word == '0 && prev_word_reg == '0)
                        begin
                            // two zero words: empty frame
                            res_valid      = 1'b1;
                            res.kind       = KIND_FRAME_END;
                            good_next      = '0;
                            prev_word_next = SEEK_IDLE_WORD;
                        end
                        else if (is_start && prev_word_reg == word)
                        begin
                            cc_mode_next = (word == START_CC);
                            good_next    = '0;
                            if (max_blocks == '0)
                            begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_FRAME_END;
                                prev_word_next = SEEK_IDLE_WORD;
                            end
                            else
                            begin
                                phase_next     = PH_CHECK;
                                prev_word_next = SEEK_IDLE_WORD;
                            end
                        end
                        else
                        begin
                            // reversed sync word shifts pairing by one byte
                            if (word == START_REVERSED)
                            begin
                                drop_next = 1'b1;
                            end
                            prev_word_next = word;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (is_start)
                        begin
                            res_valid       = 1'b1;
                            res.kind        = KIND_FRAME_END;
                            res.frame_count = good_reg;
                            cc_mode_next    = (word == START_CC);
                            good_next       = '0;
                        end
                        else if (word == '0)
                        begin
                            res_valid       = 1'b1;
                            res.kind        = KIND_FRAME_END;
                            res.frame_count = good_reg;
                            phase_next      = PH_SEEK;
                            prev_word_next  = SEEK_IDLE_WORD;
                        end
                        else
                        begin
                            exp_sum_next   = word;
                            run_sum_next   = '0;
                            field_idx_next = '0;
                            phase_next     = PH_FIELDS;
                        end
                    end
                    PH_FIELDS:
                    begin
                        for (int i = 0; i < NUM_HELD; i++)
                        begin
                            if (field_idx_reg == 3'(i))
                            begin
                                held_next[i] = word;
                            end
                        end
                        run_sum_next = sum_now;
                        if (field_idx_reg < last_idx)
                        begin
                            field_idx_next = field_idx_reg + 3'd1;
                        end
                        else
                        begin
                            phase_next     = PH_TRAIL;
                            field_idx_next = '0;
                            res_valid      = 1'b1;
                            if (sum_now == exp_sum_reg)
                            begin
                                good_next         = good_reg + 6'd1;
                                res.kind          = KIND_BLOCK;
                                res.signature     = held_reg[0];
                                res.pos_x         = held_reg[1];
                                res.pos_y         = held_reg[2];
                                res.box_width     = held_reg[3];
                                res.box_height    = field_idx_reg == LAST_NORMAL ?
                                                    word : held_reg[4];
                                res.angle         = cc_mode_reg ? word : '0;
                                res.is_color_code = cc_mode_reg;
                            end
                            else
                            begin
                                res.kind = KIND_CSUM_ERR;
                            end
                        end
                    end
                    PH_TRAIL:
                    begin
                        if (is_start && good_reg < max_blocks)
                        begin
                            cc_mode_next = (word == START_CC);
                            phase_next   = PH_CHECK;
                        end
                        else
                        begin
                            res_valid       = 1'b1;
                            res.kind        = KIND_FRAME_END;
                            res.frame_count = good_reg;
                            phase_next      = PH_SEEK;
                            prev_word_next  = SEEK_IDLE_WORD;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SEEK;
                    end
                endcase
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEEK;
            byte_phase_reg <= 1'b0;
            low_half_reg   <= '0;
            drop_reg       <= 1'b0;
            prev_word_reg  <= SEEK_IDLE_WORD;
            exp_sum_reg    <= '0;
            run_sum_reg    <= '0;
            field_idx_reg  <= '0;
            cc_mode_reg    <= 1'b0;
            good_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_phase_reg <= byte_phase_next;
            low_half_reg   <= low_half_next;
            drop_reg       <= drop_next;
            prev_word_reg  <= prev_word_next;
            exp_sum_reg    <= exp_sum_next;
            run_sum_reg    <= run_sum_next;
            field_idx_reg  <= field_idx_next;
            cc_mode_reg    <= cc_mode_next;
            good_reg       <= good_next;
        end
    end

    // held block words
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_HELD; i++)
        begin
            held_reg[i] <= held_next[i];
        end
    end

endmodule

@@ design/camera_block_frame_parser.sv @@
// top level: config register, input stage, parser and result register
// a result beat is registered as the byte that completes it leaves the input stage
// throughput: one byte beat per cycle while the result side does not stall
// stall towards the sender is registered; the parser state machine does one byte a step
// reset (rst_n, asynchronous): seeking frame start, no result pending, max_blocks 30
module camera_block_frame_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbfp_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cbfp_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cbfp_pkg::KIND_W-1:0]   result_kind,
    output logic [cbfp_pkg::WORD_W-1:0]   signature,
    output logic [cbfp_pkg::WORD_W-1:0]   pos_x,
    output logic [cbfp_pkg::WORD_W-1:0]   pos_y,
    output logic [cbfp_pkg::WORD_W-1:0]   box_width,
    output logic [cbfp_pkg::WORD_W-1:0]   box_height,
    output logic [cbfp_pkg::WORD_W-1:0]   angle,
    output logic                          is_color_code,
    output logic [cbfp_pkg::COUNT_W-1:0]  frame_count
);
    import cbfp_pkg::*;

    logic [COUNT_W-1:0] max_blocks_reg;
    logic               stage_valid;
    logic [BYTE_W-1:0]  stage_byte;
    logic               advance;
    logic               res_valid;
    result_t            res;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    assign cfg_ready = 1'b1;

    // stage moves on when the result register is free or being emptied
    assign advance = stage_valid && (!out_valid_reg || !out_stall);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_blocks_reg <= MAX_BLOCKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_blocks_reg <= cfg_data;
        end
    end

    cbfp_input_skid u_skid (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    cbfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .byte_in    (stage_byte),
        .max_blocks (max_blocks_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result beat valid
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_reg.kind;
    assign signature     = out_reg.signature;
    assign pos_x         = out_reg.pos_x;
    assign pos_y         = out_reg.pos_y;
    assign box_width     = out_reg.box_width;
    assign box_height    = out_reg.box_height;
    assign angle         = out_reg.angle;
    assign is_color_code = out_reg.is_color_code;
    assign frame_count   = out_reg.frame_count;

endmodule
